>>> rtl/core/pse_pkg.sv
// Shared constants and types for the postfix stack evaluator.
`timescale 1ns / 1ps

package pse_pkg;

    localparam int STACK_DEPTH_DEF = 64;
    localparam int VALUE_WIDTH_DEF = 32;

    // request codes
    localparam logic [2:0] REQ_PUSH = 3'd0;
    localparam logic [2:0] REQ_ADD  = 3'd1;
    localparam logic [2:0] REQ_SUB  = 3'd2;
    localparam logic [2:0] REQ_MUL  = 3'd3;
    localparam logic [2:0] REQ_END  = 3'd4;

    // sticky error codes
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_UNDER = 2'd1;
    localparam logic [1:0] ERR_OVER  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_MUL  = 3'b100
    } pse_state_t;

    // what the sequencer hands to the result register
    typedef struct packed {
        logic       fire;
        logic       done;
        logic [1:0] status;
    } pse_rsp_t;

endpackage

>>> rtl/core/pse_stack_mem.sv
// Stack storage: one write port, two registered read ports.
`timescale 1ns / 1ps

module pse_stack_mem #(
    parameter int DEPTH  = 64,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = 6
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr_a,
    input  logic [ADDR_W-1:0] raddr_b,
    output logic [WIDTH-1:0]  rdata_a,
    output logic [WIDTH-1:0]  rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

>>> rtl/core/pse_mul.sv
// Wrapping multiplier: single registered product up to 32 bits, 32-bit partial products above.
`timescale 1ns / 1ps

module pse_mul #(
    parameter int WIDTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [WIDTH-1:0] a,
    input  logic [WIDTH-1:0] b,
    output logic             done,
    output logic [WIDTH-1:0] product
);

    logic done_reg;

    assign done = done_reg;

    generate
        if (WIDTH <= 32)
        begin : g_single
            logic [WIDTH-1:0] p_reg;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    done_reg <= 1'b0;
                end
                else
                begin
                    done_reg <= start;
                end
            end

            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    p_reg <= a * b;
                end
            end

            assign product = p_reg;
        end
        else
        begin : g_split
            // low WIDTH bits of a*b = aL*bL + ((aL*bH + aH*bL) << 32)
            logic [WIDTH-1:0] a_reg;
            logic [WIDTH-1:0] b_reg;
            logic [63:0]      prod_reg;
            logic [WIDTH-1:0] acc_reg;
            logic [2:0]       step_reg;
            logic [WIDTH-1:0] cross_sh;

            assign cross_sh = {prod_reg[WIDTH-33:0], 32'b0};

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    step_reg <= 3'd0;
                    done_reg <= 1'b0;
                end
                else
                begin
                    done_reg <= (step_reg == 3'd4);
                    if (start)
                    begin
                        step_reg <= 3'd1;
                    end
                    else if (step_reg == 3'd4)
                    begin
                        step_reg <= 3'd0;
                    end
                    else if (step_reg != 3'd0)
                    begin
                        step_reg <= step_reg + 3'd1;
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    a_reg <= a;
                    b_reg <= b;
                end
                case (step_reg)
                    3'd1:
                    begin
                        prod_reg <= 64'(a_reg[31:0] * b_reg[31:0]);
                    end
                    3'd2:
                    begin
                        acc_reg  <= WIDTH'(prod_reg);
                        prod_reg <= 64'(a_reg[31:0] * b_reg[WIDTH-1:32]);
                    end
                    3'd3:
                    begin
                        acc_reg  <= acc_reg + cross_sh;
                        prod_reg <= 64'(a_reg[WIDTH-1:32] * b_reg[31:0]);
                    end
                    3'd4:
                    begin
                        acc_reg <= acc_reg + cross_sh;
                    end
                    default:
                    begin
                    end
                endcase
            end

            assign product = acc_reg;
        end
    endgenerate

endmodule

>>> rtl/core/postfix_stack_evaluator.sv
// Postfix evaluator top level: sequencer around the stack memory and multiplier.
// Strobe is registered from the execute state, or from the multiply state once the multiplier
// reports done (multiplies take longer when VALUE_WIDTH exceeds 32); words are taken only in idle.
// A new word is not accepted until the previous one, multiply included, has finished (busy low).
// The receiver cannot stall; each result is shown for exactly one cycle.
// Reset clears stack count, sticky error and sequencer; stack contents are not cleared.
`timescale 1ns / 1ps

module postfix_stack_evaluator
    import pse_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         req_type,
    input  logic [30:0]        operand,
    output logic               strobe,
    output logic [1:0]         status,
    output logic               done_res,
    output logic signed [31:0] value
);

    localparam int ADDR_W = $clog2(STACK_DEPTH);
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(STACK_DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_TWO   = CNT_W'(2);

    pse_state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [1:0]       err_reg, err_next;
    logic [2:0]       req_reg;
    logic [30:0]      opnd_reg;

    logic             strobe_reg;
    logic [1:0]       status_reg;
    logic             done_reg;
    logic [31:0]      value_reg;

    logic                   mem_we;
    logic [ADDR_W-1:0]      mem_waddr;
    logic [VALUE_WIDTH-1:0] mem_wdata;
    logic [VALUE_WIDTH-1:0] top_q;
    logic [VALUE_WIDTH-1:0] below_q;
    logic [CNT_W-1:0]       cnt_m1;
    logic [CNT_W-1:0]       cnt_m2;

    logic                   mul_start;
    logic                   mul_done;
    logic [VALUE_WIDTH-1:0] mul_p;

    pse_rsp_t               rsp;
    logic [31:0]            rsp_val;

    wire accept = start && (state_reg == S_IDLE);

    assign cnt_m1 = count_reg - CNT_ONE;
    assign cnt_m2 = count_reg - CNT_TWO;

    pse_stack_mem #(
        .DEPTH  (STACK_DEPTH),
        .WIDTH  (VALUE_WIDTH),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .raddr_a (cnt_m1[ADDR_W-1:0]),
        .raddr_b (cnt_m2[ADDR_W-1:0]),
        .rdata_a (top_q),
        .rdata_b (below_q)
    );

    pse_mul #(
        .WIDTH (VALUE_WIDTH)
    ) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (below_q),
        .b       (top_q),
        .done    (mul_done),
        .product (mul_p)
    );

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        err_next   = err_reg;
        mem_we     = 1'b0;
        mem_waddr  = count_reg[ADDR_W-1:0];
        mem_wdata  = VALUE_WIDTH'(opnd_reg);
        mul_start  = 1'b0;
        rsp.fire   = 1'b0;
        rsp.done   = 1'b0;
        rsp.status = err_reg;
        rsp_val    = 32'd0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
                rsp.fire   = 1'b1;
                case (req_reg)
                    REQ_PUSH:
                    begin
                        if (count_reg < DEPTH_CNT)
                        begin
                            mem_we     = 1'b1;
                            count_next = count_reg + CNT_ONE;
                        end
                        else if (err_reg == ERR_NONE)
                        begin
                            err_next = ERR_OVER;
                        end
                    end
                    REQ_ADD, REQ_SUB, REQ_MUL:
                    begin
                        if (count_reg < CNT_TWO)
                        begin
                            if (err_reg == ERR_NONE)
                            begin
                                err_next = ERR_UNDER;
                            end
                        end
                        else if (req_reg == REQ_MUL)
                        begin
                            mul_start  = 1'b1;
                            rsp.fire   = 1'b0;
                            state_next = S_MUL;
                        end
                        else
                        begin
                            // pop two, push one: lands where the lower operand was
                            mem_we     = 1'b1;
                            mem_waddr  = cnt_m2[ADDR_W-1:0];
                            mem_wdata  = (req_reg == REQ_ADD) ? below_q + top_q
                                                              : below_q - top_q;
                            count_next = cnt_m1;
                        end
                    end
                    REQ_END:
                    begin
                        rsp.done   = 1'b1;
                        count_next = '0;
                        err_next   = ERR_NONE;
                        if (count_reg == '0)
                        begin
                            if (err_reg == ERR_NONE)
                            begin
                                rsp.status = ERR_UNDER;
                            end
                        end
                        else
                        begin
                            rsp_val = 32'($signed(top_q));
                        end
                    end
                    default:
                    begin
                    end
                endcase
                if (req_reg != REQ_END)
                begin
                    rsp.status = err_next;
                end
            end
            S_MUL:
            begin
                if (mul_done)
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = cnt_m2[ADDR_W-1:0];
                    mem_wdata  = mul_p;
                    count_next = cnt_m1;
                    rsp.fire   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            err_reg    <= ERR_NONE;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            err_reg    <= err_next;
            strobe_reg <= rsp.fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg  <= req_type;
            opnd_reg <= operand;
        end
        if (rsp.fire)
        begin
            status_reg <= rsp.status;
            done_reg   <= rsp.done;
            value_reg  <= (rsp.status == ERR_NONE) ? rsp_val : 32'd0;
        end
    end

    assign busy     = (state_reg != S_IDLE);
    assign strobe   = strobe_reg;
    assign status   = status_reg;
    assign done_res = done_reg;
    assign value    = value_reg;

endmodule

>>> bench/postfix_stack_evaluator_tb.sv
// Self-checking bench for the postfix stack evaluator: queued words in, predicted results out.
`timescale 1ns / 1ps

module postfix_stack_evaluator_tb;
    import pse_pkg::*;

    localparam int          RAND_WORDS   = 750;
    localparam int          STALL_LIMIT  = 1000;
    localparam int          DRAIN_CYCLES = 12;
    localparam logic [30:0] OPND_MAX     = 31'h7FFF_FFFF;
    localparam logic [2:0]  REQ_CODE_TOP = 3'd7;

    typedef struct packed {
        logic [2:0]  req;
        logic [30:0] opnd;
    } word_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        done;
        logic [31:0] value;
    } result_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [2:0]         req_type;
    logic [30:0]        operand;
    logic               strobe;
    logic [1:0]         status;
    logic               done_res;
    logic signed [31:0] value;

    word_t   word_queue[$];
    result_t pending_results[$];

    // predictor state
    logic [31:0] calc_stack [STACK_DEPTH_DEF];
    int          calc_depth;
    logic [1:0]  calc_err;

    logic word_taken;
    int   words_sent;
    int   fail_count;
    int   stall_cycles;
    int   counted_words;
    int   exprs_ok;
    int   exprs_under;
    int   exprs_over;

    postfix_stack_evaluator uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .req_type (req_type),
        .operand  (operand),
        .strobe   (strobe),
        .status   (status),
        .done_res (done_res),
        .value    (value)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    task automatic raise_error(input logic [1:0] code);
        if (calc_err == ERR_NONE)
            calc_err = code;
    endtask

    task automatic stack_push(input logic [31:0] v);
        if (calc_depth >= STACK_DEPTH_DEF)
            raise_error(ERR_OVER);
        else
        begin
            calc_stack[calc_depth] = v;
            calc_depth++;
        end
    endtask

    // apply one accepted word and return the result it produces
    task automatic evaluate_word(input word_t w, output result_t r);
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] res;
        r = '0;
        case (w.req)
            REQ_PUSH: stack_push({1'b0, w.opnd});
            REQ_ADD, REQ_SUB, REQ_MUL:
            begin
                if (calc_depth < 2)
                    raise_error(ERR_UNDER);
                else
                begin
                    b = calc_stack[calc_depth - 1];
                    a = calc_stack[calc_depth - 2];
                    if (w.req == REQ_ADD)
                        res = a + b;
                    else if (w.req == REQ_SUB)
                        res = a - b;
                    else
                        res = a * b;
                    calc_depth -= 2;
                    stack_push(res);
                end
            end
            REQ_END:
            begin
                r.done = 1'b1;
                if (calc_depth == 0)
                    raise_error(ERR_UNDER);
                else if (calc_err == ERR_NONE)
                    r.value = calc_stack[calc_depth - 1];
            end
            default: ;
        endcase
        r.status = calc_err;
        if (calc_err != ERR_NONE)
            r.value = '0;
        if (w.req == REQ_END)
        begin
            calc_depth = 0;
            calc_err   = ERR_NONE;
        end
    endtask

    task automatic add_word(input logic [2:0] req, input logic [30:0] opnd);
        word_t w;
        w.req  = req;
        w.opnd = opnd;
        word_queue.push_back(w);
        if (req <= REQ_END)
            counted_words++;
    endtask

    function automatic logic [30:0] pick_operand();
        int sel;
        sel = $urandom_range(9);
        if (sel == 0)
            return '0;
        else if (sel == 1)
            return OPND_MAX;
        else if (sel < 5)
            return 31'($urandom_range(100));
        else
            return 31'($urandom);
    endfunction

    function automatic logic [2:0] pick_operator();
        int sel;
        sel = $urandom_range(2);
        if (sel == 0)
            return REQ_ADD;
        else if (sel == 1)
            return REQ_SUB;
        else
            return REQ_MUL;
    endfunction

    // well-formed expression of random shape and content
    task automatic add_expression();
        int depth;
        int len;
        int target;
        depth  = 0;
        len    = 0;
        target = $urandom_range(1, 14);
        while (len < target || depth != 1)
        begin
            if (depth < 2 || (len < target && $urandom_range(1) == 0))
            begin
                add_word(REQ_PUSH, pick_operand());
                depth++;
            end
            else
            begin
                add_word(pick_operator(), '0);
                depth--;
            end
            len++;
        end
        add_word(REQ_END, '0);
    endtask

    // fill the stack close to or past its limit, fold some of it back, then end
    task automatic add_deep_run();
        int n;
        int folds;
        n     = $urandom_range(STACK_DEPTH_DEF - 4, STACK_DEPTH_DEF + 4);
        folds = $urandom_range(n + 1);
        for (int i = 0; i < n; i++)
            add_word(REQ_PUSH, pick_operand());
        for (int i = 0; i < folds; i++)
            add_word(pick_operator(), '0);
        add_word(REQ_END, '0);
    endtask

    // random codes, unused ones included; sometimes finishes with an end
    task automatic add_noise();
        int n;
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++)
            add_word(3'($urandom_range(REQ_CODE_TOP)), 31'($urandom));
        if ($urandom_range(1) == 0)
            add_word(REQ_END, '0);
    endtask

    // driver: new word or gap at each falling edge once the current one is taken
    always @(negedge clk)
    begin : drive_words
        word_t w;
        logic  quiet;
        if (!rst_n)
            start <= 1'b0;
        else if (!start || word_taken)
        begin
            quiet = (words_sent >= 300 && words_sent < 420);
            if (word_queue.size() != 0 && (quiet || $urandom_range(99) >= 28))
            begin
                w = word_queue.pop_front();
                start    <= 1'b1;
                req_type <= w.req;
                operand  <= w.opnd;
                words_sent++;
            end
            else
            begin
                start    <= 1'b0;
                req_type <= 3'($urandom);
                operand  <= 31'($urandom);
            end
        end
    end

    // monitor: check results, then predict for the word accepted at this edge
    always @(posedge clk)
    begin : watch_results
        result_t exp_r;
        result_t got_r;
        word_t   w;
        logic    accepted;
        accepted = rst_n && start && !busy;
        word_taken <= accepted;
        if (rst_n && strobe)
        begin
            got_r.status = status;
            got_r.done   = done_res;
            got_r.value  = value;
            if (pending_results.size() == 0)
            begin
                $error("result word with nothing expected: status %0d done %0d value %0d",
                       status, done_res, value);
                fail_count++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (got_r.status !== exp_r.status)
                begin
                    $error("status: expected %0d, got %0d", exp_r.status, got_r.status);
                    fail_count++;
                end
                if (got_r.done !== exp_r.done)
                begin
                    $error("done_res: expected %0d, got %0d", exp_r.done, got_r.done);
                    fail_count++;
                end
                if (got_r.value !== exp_r.value)
                begin
                    $error("value: expected %0d, got %0d",
                           $signed(exp_r.value), $signed(got_r.value));
                    fail_count++;
                end
            end
        end
        if (accepted)
        begin
            w.req  = req_type;
            w.opnd = operand;
            evaluate_word(w, exp_r);
            pending_results.push_back(exp_r);
            if (exp_r.done)
            begin
                if (exp_r.status == ERR_NONE)
                    exprs_ok++;
                else if (exp_r.status == ERR_UNDER)
                    exprs_under++;
                else
                    exprs_over++;
            end
        end
        if (!rst_n || accepted || strobe)
            stall_cycles = 0;
        else if (word_queue.size() != 0 || pending_results.size() != 0 || start)
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        start         = 1'b0;
        req_type      = REQ_PUSH;
        operand       = '0;
        word_taken    = 1'b0;
        words_sent    = 0;
        fail_count    = 0;
        stall_cycles  = 0;
        counted_words = 0;
        exprs_ok      = 0;
        exprs_under   = 0;
        exprs_over    = 0;
        calc_depth    = 0;
        calc_err      = ERR_NONE;

        // extremes: add wraps positive to negative
        add_word(REQ_PUSH, OPND_MAX);
        add_word(REQ_PUSH, OPND_MAX);
        add_word(REQ_ADD, '0);
        add_word(REQ_END, '0);
        // subtract below zero
        add_word(REQ_PUSH, '0);
        add_word(REQ_PUSH, OPND_MAX);
        add_word(REQ_SUB, '0);
        add_word(REQ_END, '0);
        // multiply wraps
        add_word(REQ_PUSH, OPND_MAX);
        add_word(REQ_PUSH, 31'd3);
        add_word(REQ_MUL, '0);
        add_word(REQ_END, '0);
        // operator on empty stack, later words still applied, error held to end
        add_word(REQ_ADD, '0);
        add_word(REQ_PUSH, 31'd5);
        add_word(REQ_END, '0);
        // end with nothing on the stack
        add_word(REQ_END, '0);
        // leftover entries dropped at end
        add_word(REQ_PUSH, 31'd1);
        add_word(REQ_PUSH, 31'd2);
        add_word(REQ_PUSH, 31'd3);
        add_word(REQ_END, '0);
        // unused codes
        add_word(3'd5, OPND_MAX);
        add_word(3'd6, '0);
        add_word(REQ_CODE_TOP, 31'h5555_5555);

        add_deep_run();
        while (counted_words < RAND_WORDS)
        begin
            case ($urandom_range(9))
                0:       add_deep_run();
                1, 2:    add_noise();
                default: add_expression();
            endcase
        end

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (word_queue.size() != 0 || start || pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d words sent, %0d expressions ended", words_sent,
                 exprs_ok + exprs_under + exprs_over);
        $display("  %0d clean, %0d underflow, %0d overflow", exprs_ok, exprs_under,
                 exprs_over);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> files.f
rtl/core/pse_pkg.sv
rtl/core/pse_stack_mem.sv
rtl/core/pse_mul.sv
rtl/core/postfix_stack_evaluator.sv
bench/postfix_stack_evaluator_tb.sv
